// ===== hdl/grr_pkg.sv =====
// grr_pkg: shared types and constants for the graph reachability block.
// No dependencies; used by the interfaces and every module in hdl/.
package grr_pkg;

  localparam int NodeW  = 6;   // width of a vertex field on the input beat
  localparam int CountW = 7;   // width of the node_count register
  localparam int AddrW  = 3;   // APB byte address width
  localparam int DataW  = 32;  // APB data width

  localparam logic [CountW-1:0] NodeCountReset = CountW'(64);

  // Register byte addresses, decoded on paddr[AddrW-1:2]
  localparam logic [AddrW-3:0] RegNodeCount = '0;

  typedef enum logic [1:0] {
    ActAdd   = 2'd0,
    ActQuery = 2'd1,
    ActClear = 2'd2
  } action_e;

  // Adjacency memory control
  typedef struct packed {
    logic clear;  // drop every row at once
    logic wr_en;  // write one row
  } mem_ctrl_t;

  // Frontier unit control and status
  typedef struct packed {
    logic load;   // restart with only the source marked
    logic step;   // merge the row just read
  } frn_ctrl_t;

  typedef struct packed {
    logic dst_hit;  // destination already marked
    logic grew;     // this cycle's row was expanded
  } frn_status_t;

endpackage

// ===== hdl/grr_if.sv =====
// grr_if: valid/ready channel interfaces for the input and result beats.
// Depends on grr_pkg for field widths.
interface grr_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               action;
  logic [grr_pkg::NodeW-1:0] node_a;
  logic [grr_pkg::NodeW-1:0] node_b;

  modport source (output valid, action, node_a, node_b, input ready);
  modport sink   (input valid, action, node_a, node_b, output ready);
endinterface

interface grr_out_if;
  logic valid;
  logic ready;
  logic reachable;
  logic out_of_range;

  modport source (output valid, reachable, out_of_range, input ready);
  modport sink   (input valid, reachable, out_of_range, output ready);
endinterface

// ===== hdl/grr_adj_mem.sv =====
// grr_adj_mem: adjacency row memory, one write and one registered read a cycle.
// Per-row valid flops make a cleared or never-written row read as zero.
// Depends on grr_pkg.
module grr_adj_mem #(
  parameter int NumRows = 64,
  parameter int IdxW    = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  grr_pkg::mem_ctrl_t    ctrl_i,
  input  logic [IdxW-1:0]       waddr_i,
  input  logic [NumRows-1:0]    wdata_i,
  input  logic [IdxW-1:0]       raddr_i,
  output logic [NumRows-1:0]    row_o
);

  logic [NumRows-1:0] mem_q [NumRows];
  logic [NumRows-1:0] valid_q;
  logic [NumRows-1:0] rdata_q;
  logic               rvld_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      rvld_q  <= 1'b0;
    end else begin
      rvld_q <= valid_q[raddr_i];
      if (ctrl_i.clear) begin
        valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        valid_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign row_o = rvld_q ? rdata_q : '0;

endmodule

// ===== hdl/grr_frontier.sv =====
// grr_frontier: visited/expanded vertex sets and the shared row-merge unit.
// Depends on grr_pkg.
module grr_frontier #(
  parameter int NumRows = 64,
  parameter int IdxW    = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  grr_pkg::frn_ctrl_t    ctrl_i,
  input  logic [IdxW-1:0]       src_i,
  input  logic [IdxW-1:0]       dst_i,
  input  logic [IdxW-1:0]       pidx_i,
  input  logic [NumRows-1:0]    row_i,
  input  logic [NumRows-1:0]    mask_i,
  output grr_pkg::frn_status_t  status_o
);

  localparam logic [NumRows-1:0] OneBit = {{(NumRows-1){1'b0}}, 1'b1};

  logic [NumRows-1:0] visited_q, visited_d;
  logic [NumRows-1:0] done_q, done_d;
  logic               expand;

  // expand a vertex once: marked but not yet merged
  assign expand = ctrl_i.step && visited_q[pidx_i] && !done_q[pidx_i];

  always_comb begin
    visited_d = visited_q;
    done_d    = done_q;
    if (ctrl_i.load) begin
      visited_d = OneBit << src_i;
      done_d    = '0;
    end else if (expand) begin
      visited_d = visited_q | (row_i & mask_i);
      done_d    = done_q | (OneBit << pidx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      visited_q <= '0;
      done_q    <= '0;
    end else begin
      visited_q <= visited_d;
      done_q    <= done_d;
    end
  end

  assign status_o.dst_hit = visited_q[dst_i];
  assign status_o.grew    = expand;

endmodule

// ===== hdl/graph_reachability.sv =====
// graph_reachability: undirected reachability over a stored adjacency bit matrix.
// Add and clear beats give no result; a query beat gives one result beat, after a
// sweep-based walk if its vertices are in range. Depends on grr_pkg, grr_if, grr_adj_mem and grr_frontier.
//
// Operation: the block takes one input beat at a time and is not ready while it
// works. A clear drops the row valid flags at once (so there is no clearing pass
// after reset either). An add edge makes two read-modify-write passes through the
// adjacency memory: read row a, write row a with bit b, read row b, write row b
// with bit a. A query with a vertex out of range goes straight to the result
// state. An in-range query sweeps the live vertices (L = min(node_count,
// MAX_NODES, 64)) in order, one adjacency row a cycle through the one memory read
// port, and merges each marked, not yet expanded row into the visited set in
// the shared merge unit. Sweeps repeat while the previous one expanded a
// vertex, and a query ends as soon as the destination is marked. A finished
// result sits in an output register, so the next beat is taken while it waits.
module graph_reachability #(
  parameter int MAX_NODES = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  grr_in_if.sink                            in_i,
  grr_out_if.source                         out_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [grr_pkg::AddrW-1:0]         paddr,
  input  logic [grr_pkg::DataW-1:0]         pwdata,
  output logic [grr_pkg::DataW-1:0]         prdata,
  output logic                              pready
);

  // Vertex fields are 6 bits, so no more than 64 rows are ever addressed.
  localparam int NumRows = (MAX_NODES < 64) ? MAX_NODES : 64;
  localparam int IdxW    = $clog2(NumRows);
  localparam int CountW  = grr_pkg::CountW;
  localparam logic [NumRows-1:0] OneBit = {{(NumRows-1){1'b0}}, 1'b1};

  // Sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_ADD_RA = 3'd1;  // read row a
  localparam logic [2:0] S_ADD_WA = 3'd2;  // write row a with bit b
  localparam logic [2:0] S_ADD_RB = 3'd3;  // read row b
  localparam logic [2:0] S_ADD_WB = 3'd4;  // write row b with bit a
  localparam logic [2:0] S_WALK   = 3'd5;  // sweep rows
  localparam logic [2:0] S_RESULT = 3'd6;  // hand result to the output register

  logic [2:0]          state_q, state_d;
  logic [CountW-1:0]   node_count_q;
  logic [CountW-1:0]   limit;
  logic                a_ok, b_ok;

  logic [IdxW-1:0]     a_q, a_d, b_q, b_d;
  logic [IdxW-1:0]     last_q, last_d;
  logic [NumRows-1:0]  mask_q, mask_d;
  logic [IdxW-1:0]     scan_q, scan_d;
  logic                issuing_q, issuing_d;
  logic [IdxW-1:0]     pidx_q, pidx_d;
  logic                pval_q, pval_d;
  logic                change_q, change_d;

  logic                pend_reach_q, pend_reach_d;
  logic                pend_oor_q, pend_oor_d;
  logic                res_valid_q, res_valid_d;
  logic                res_reach_q, res_reach_d;
  logic                res_oor_q, res_oor_d;

  grr_pkg::mem_ctrl_t    mem_ctrl;
  logic [IdxW-1:0]       mem_waddr, mem_raddr;
  logic [NumRows-1:0]    mem_wdata, row;
  grr_pkg::frn_ctrl_t    frn_ctrl;
  grr_pkg::frn_status_t  frn_st;

  logic                  in_beat, out_beat, cfg_wr;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= grr_pkg::NodeCountReset;
    end else if (cfg_wr && paddr[grr_pkg::AddrW-1:2] == grr_pkg::RegNodeCount) begin
      node_count_q <= pwdata[CountW-1:0];
    end
  end

  assign prdata = (paddr[grr_pkg::AddrW-1:2] == grr_pkg::RegNodeCount) ?
                  grr_pkg::DataW'(node_count_q) : '0;

  // live vertex count, capped at the stored rows
  assign limit = (node_count_q > CountW'(NumRows)) ? CountW'(NumRows) : node_count_q;
  assign a_ok  = {1'b0, in_i.node_a} < limit;
  assign b_ok  = {1'b0, in_i.node_b} < limit;

  // ---------------------------------------------------------------------------
  // Handshake
  // ---------------------------------------------------------------------------
  assign in_i.ready        = (state_q == S_IDLE);
  assign in_beat           = in_i.valid && in_i.ready;
  assign out_o.valid       = res_valid_q;
  assign out_o.reachable   = res_reach_q;
  assign out_o.out_of_range = res_oor_q;
  assign out_beat          = out_o.valid && out_o.ready;

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d      = state_q;
    a_d          = a_q;
    b_d          = b_q;
    last_d       = last_q;
    mask_d       = mask_q;
    scan_d       = scan_q;
    issuing_d    = issuing_q;
    pidx_d       = pidx_q;
    pval_d       = 1'b0;
    change_d     = change_q;
    pend_reach_d = pend_reach_q;
    pend_oor_d   = pend_oor_q;
    res_valid_d  = res_valid_q && !out_beat;
    res_reach_d  = res_reach_q;
    res_oor_d    = res_oor_q;

    mem_ctrl     = '0;
    mem_waddr    = a_q;
    mem_wdata    = row | (OneBit << b_q);
    mem_raddr    = scan_q;
    frn_ctrl     = '0;

    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          a_d = in_i.node_a[IdxW-1:0];
          b_d = in_i.node_b[IdxW-1:0];
          case (in_i.action)
            grr_pkg::ActAdd: begin
              // edges with an endpoint out of range are dropped
              if (a_ok && b_ok) begin
                state_d = S_ADD_RA;
              end
            end
            grr_pkg::ActClear: begin
              mem_ctrl.clear = 1'b1;
            end
            grr_pkg::ActQuery: begin
              if (a_ok && b_ok) begin
                // source taken straight from the beat being accepted
                frn_ctrl.load = 1'b1;
                last_d        = IdxW'(limit - CountW'(1));
                for (int i = 0; i < NumRows; i++) begin
                  mask_d[i] = CountW'(i) < limit;
                end
                scan_d        = '0;
                issuing_d     = 1'b1;
                change_d      = 1'b0;
                state_d       = S_WALK;
              end else begin
                pend_reach_d = 1'b0;
                pend_oor_d   = 1'b1;
                state_d      = S_RESULT;
              end
            end
            default: begin
              // unused action: no effect
            end
          endcase
        end
      end

      S_ADD_RA: begin
        mem_raddr = a_q;
        state_d   = S_ADD_WA;
      end

      S_ADD_WA: begin
        mem_ctrl.wr_en = 1'b1;
        state_d        = S_ADD_RB;
      end

      S_ADD_RB: begin
        mem_raddr = b_q;
        state_d   = S_ADD_WB;
      end

      S_ADD_WB: begin
        mem_ctrl.wr_en = 1'b1;
        mem_waddr      = b_q;
        mem_wdata      = row | (OneBit << a_q);
        state_d        = S_IDLE;
      end

      S_WALK: begin
        // read of row scan_q is issued now, merged next cycle as pidx_q
        frn_ctrl.step = pval_q;
        if (frn_st.dst_hit) begin
          pend_reach_d = 1'b1;
          pend_oor_d   = 1'b0;
          state_d      = S_RESULT;
        end else begin
          pval_d = issuing_q;
          pidx_d = scan_q;
          if (issuing_q) begin
            if (scan_q == last_q) begin
              issuing_d = 1'b0;
            end else begin
              scan_d = scan_q + IdxW'(1);
            end
          end
          if (pval_q) begin
            change_d = change_q | frn_st.grew;
            if (pidx_q == last_q) begin
              if (change_q || frn_st.grew) begin
                // something grew: sweep again
                scan_d    = '0;
                issuing_d = 1'b1;
                change_d  = 1'b0;
              end else begin
                pend_reach_d = 1'b0;
                pend_oor_d   = 1'b0;
                state_d      = S_RESULT;
              end
            end
          end
        end
      end

      S_RESULT: begin
        if (!res_valid_q || out_beat) begin
          res_valid_d = 1'b1;
          res_reach_d = pend_reach_q;
          res_oor_d   = pend_oor_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      issuing_q   <= 1'b0;
      pval_q      <= 1'b0;
      change_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      issuing_q   <= issuing_d;
      pval_q      <= pval_d;
      change_q    <= change_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q          <= a_d;
    b_q          <= b_d;
    last_q       <= last_d;
    mask_q       <= mask_d;
    scan_q       <= scan_d;
    pidx_q       <= pidx_d;
    pend_reach_q <= pend_reach_d;
    pend_oor_q   <= pend_oor_d;
    res_reach_q  <= res_reach_d;
    res_oor_q    <= res_oor_d;
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  grr_adj_mem #(
    .NumRows (NumRows),
    .IdxW    (IdxW)
  ) u_adj_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .row_o   (row)
  );

  grr_frontier #(
    .NumRows (NumRows),
    .IdxW    (IdxW)
  ) u_frontier (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (frn_ctrl),
    .src_i    (a_d),
    .dst_i    (b_q),
    .pidx_i   (pidx_q),
    .row_i    (row),
    .mask_i   (mask_q),
    .status_o (frn_st)
  );

`ifndef SYNTHESIS
  // merged row never lies past the live vertex range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WALK && pval_q) |-> (pidx_q <= last_q))
    else $error("walk merged a row beyond the live range");

  // an out-of-range result never claims a path
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.out_of_range) |-> !out_o.reachable)
    else $error("out-of-range result marked reachable");

  // a new result beat only follows the result state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_q) |-> ($past(state_q) == S_RESULT))
    else $error("result raised outside the result state");

  // an edge add finishes its second write and returns to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ADD_WB) |=> (state_q == S_IDLE))
    else $error("edge add did not complete");
`endif

endmodule

// ===== tb/grr_tb_pkg.sv =====
// grr_tb_pkg: scoreboard for the graph reachability testbench.
// Holds a shadow adjacency matrix and node_count, predicts query answers.
// Depends on grr_pkg.
package grr_tb_pkg;

  typedef struct packed {
    logic reachable;
    logic out_of_range;
  } answer_t;

  class reach_book;
    logic [63:0]                adj_rows [64];
    logic [grr_pkg::CountW-1:0] node_count;
    answer_t                    pending_answers [$];
    int                         mismatches;

    function new();
      wipe_rows();
      node_count  = grr_pkg::NodeCountReset;
      mismatches  = 0;
    endfunction

    function void wipe_rows();
      foreach (adj_rows[r]) adj_rows[r] = '0;
    endfunction

    function int live_limit();
      return (int'(node_count) > 64) ? 64 : int'(node_count);
    endfunction

    // frontier expansion to a fixed point; same visited set as a depth-first walk
    function logic walk_reach(int src, int dst, int lim);
      logic [63:0] seen;
      logic [63:0] span;
      logic [63:0] grown;
      bit          moved;
      span = (lim >= 64) ? '1 : ((64'd1 << lim) - 64'd1);
      seen = 64'd1 << src;
      do begin
        moved = 1'b0;
        for (int x = 0; x < lim; x++) begin
          if (seen[x]) begin
            grown = seen | (adj_rows[x] & span);
            if (grown != seen) begin
              seen  = grown;
              moved = 1'b1;
            end
          end
        end
      end while (moved);
      return seen[dst];
    endfunction

    // called for every accepted input beat
    function void note_beat(logic [1:0] act, logic [grr_pkg::NodeW-1:0] a,
                            logic [grr_pkg::NodeW-1:0] b);
      int      lim;
      answer_t ans;
      lim = live_limit();
      case (act)
        grr_pkg::ActAdd: begin
          if (a < lim && b < lim) begin
            adj_rows[a][b] = 1'b1;
            adj_rows[b][a] = 1'b1;
          end
        end
        grr_pkg::ActClear: wipe_rows();
        grr_pkg::ActQuery: begin
          if (a >= lim || b >= lim) begin
            ans.reachable    = 1'b0;
            ans.out_of_range = 1'b1;
          end else begin
            ans.reachable    = walk_reach(a, b, lim);
            ans.out_of_range = 1'b0;
          end
          pending_answers = {pending_answers, ans};
        end
        default: ;
      endcase
    endfunction

    // called for every accepted result beat
    function void check_answer(logic reach, logic oor);
      answer_t want;
      if (pending_answers.size() == 0) begin
        $display("%0t: unexpected result beat: reachable=%b out_of_range=%b",
                 $time, reach, oor);
        mismatches++;
        return;
      end
      want = pending_answers.pop_front();
      if (reach !== want.reachable) begin
        $display("%0t: reachable expected %b actual %b", $time, want.reachable, reach);
        mismatches++;
      end
      if (oor !== want.out_of_range) begin
        $display("%0t: out_of_range expected %b actual %b", $time, want.out_of_range, oor);
        mismatches++;
      end
    endfunction
  endclass

endpackage

// ===== tb/graph_reachability_tb.sv =====
// graph_reachability_tb: self-checking regression for graph_reachability.
// Directed and random edge/query/clear beats over several node_count settings,
// checked against a shadow matrix in grr_tb_pkg. Needs grr_pkg, grr_if and the RTL.
module graph_reachability_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] ActSpare    = 2'd3;        // unused action, block ignores it
  localparam int         PhaseItems  = 60;
  localparam int         HoldPhase   = 5;           // phase with the long output hold-off
  localparam int         HoldCycles  = 400;
  localparam int         SettleWait  = 16;          // an add may still be in flight
  localparam longint     CycleLimit  = 64'd15_000_000;

  // node_count per random phase: small sizes mostly, extremes and clamping included
  localparam int NumPhases = 12;
  localparam logic [grr_pkg::CountW-1:0] PhaseCounts [NumPhases] =
    '{7'd8, 7'd1, 7'd0, 7'd127, 7'd2, 7'd16, 7'd100, 7'd5, 7'd64, 7'd12, 7'd3, 7'd33};

  logic clk_i;
  logic rst_ni;

  // APB side
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [grr_pkg::AddrW-1:0]  paddr;
  logic [grr_pkg::DataW-1:0]  pwdata;
  logic [grr_pkg::DataW-1:0]  prdata;
  logic                       pready;

  grr_in_if  in_ch ();
  grr_out_if out_ch ();

  grr_tb_pkg::reach_book book = new();

  bit     calm;          // no idling on either side
  bit     hold_req;      // ask the result side for one long hold-off
  int     cfg_errors;
  longint cycles = 0;

  graph_reachability dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Watchdog: only a hang gets this far
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("graph_reachability regression: fail");
      $finish;
    end
  end

  // Monitors sample at the edge, before any of this edge's updates land
  always @(posedge clk_i) begin
    if (rst_ni && in_ch.valid && in_ch.ready)
      book.note_beat(in_ch.action, in_ch.node_a, in_ch.node_b);
    if (rst_ni && out_ch.valid && out_ch.ready)
      book.check_answer(out_ch.reachable, out_ch.out_of_range);
  end

  // Result side: random stalls, ready stretches, and on request one long hold-off
  // while the sender keeps offering, so the output register fills and input stalls.
  initial begin
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(15, 1)) @(posedge clk_i);
      end else begin
        out_ch.ready <= 1'b1;
        repeat ($urandom_range(20, 1)) @(posedge clk_i);
      end
    end
  end

  // Offer one beat, with an optional idle burst first; returns at the accepting edge.
  // valid is left high so a back-to-back beat needs no second assignment.
  task automatic send_beat(logic [1:0] act, logic [grr_pkg::NodeW-1:0] a,
                           logic [grr_pkg::NodeW-1:0] b);
    if (!calm && $urandom_range(3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(15, 1)) @(posedge clk_i);
    end
    in_ch.valid  <= 1'b1;
    in_ch.action <= act;
    in_ch.node_a <= a;
    in_ch.node_b <= b;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Drop valid, wait for every outstanding answer, then let a trailing add finish.
  // One edge first so the monitor has booked the last accepted beat.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (book.pending_answers.size() != 0) @(posedge clk_i);
    repeat (SettleWait) @(posedge clk_i);
  endtask

  // APB write of node_count, then read it back
  task automatic program_count(logic [grr_pkg::CountW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {grr_pkg::RegNodeCount, 2'b00};
    pwdata  <= grr_pkg::DataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    book.node_count = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[grr_pkg::CountW-1:0] !== value) begin
      $display("%0t: node_count readback expected %0d actual %0d",
               $time, value, prdata[grr_pkg::CountW-1:0]);
      cfg_errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic logic [grr_pkg::NodeW-1:0] pick_node();
    int lim;
    lim = book.live_limit();
    if (lim > 0 && $urandom_range(99) < 85)
      return grr_pkg::NodeW'($urandom_range(lim - 1));
    return grr_pkg::NodeW'($urandom_range(63));
  endfunction

  // Mostly adds and queries on a growing graph; occasional clears and spare actions
  task automatic run_random(int count);
    int                         r;
    logic [grr_pkg::NodeW-1:0]  a;
    logic [grr_pkg::NodeW-1:0]  b;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      a = pick_node();
      b = ($urandom_range(19) == 0) ? a : pick_node();
      if (r < 3)       send_beat(grr_pkg::ActClear, a, b);
      else if (r < 5)  send_beat(ActSpare, a, b);
      else if (r < 50) send_beat(grr_pkg::ActAdd, a, b);
      else             send_beat(grr_pkg::ActQuery, a, b);
    end
  endtask

  initial begin
    in_ch.valid  = 1'b0;
    in_ch.action = grr_pkg::ActAdd;
    in_ch.node_a = '0;
    in_ch.node_b = '0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    calm         = 1'b0;
    hold_req     = 1'b0;
    cfg_errors   = 0;
    rst_ni       = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed, node_count at its reset value of 64
    send_beat(grr_pkg::ActClear, 6'd0, 6'd0);
    send_beat(grr_pkg::ActAdd,   6'd0, 6'd63);      // extreme endpoints
    send_beat(grr_pkg::ActQuery, 6'd0, 6'd63);
    send_beat(grr_pkg::ActQuery, 6'd63, 6'd0);      // symmetric bit
    send_beat(grr_pkg::ActAdd,   6'd7, 6'd7);       // self loop, diagonal only
    send_beat(grr_pkg::ActQuery, 6'd7, 6'd8);
    send_beat(grr_pkg::ActQuery, 6'd7, 6'd7);       // source equals destination
    send_beat(grr_pkg::ActAdd,   6'd1, 6'd2);
    send_beat(grr_pkg::ActAdd,   6'd2, 6'd3);
    send_beat(grr_pkg::ActAdd,   6'd3, 6'd62);
    send_beat(grr_pkg::ActQuery, 6'd1, 6'd62);      // three-hop chain
    send_beat(grr_pkg::ActQuery, 6'd62, 6'd1);
    send_beat(grr_pkg::ActQuery, 6'd0, 6'd1);       // separate components
    send_beat(ActSpare,          6'd63, 6'd63);     // ignored
    send_beat(grr_pkg::ActAdd,   6'd10, 6'd20);
    send_beat(grr_pkg::ActQuery, 6'd0, 6'd0);
    settle();

    // Count lowered below stored edges; out-of-range adds and queries
    program_count(7'd8);
    send_beat(grr_pkg::ActQuery, 6'd0, 6'd9);
    send_beat(grr_pkg::ActQuery, 6'd9, 6'd0);
    send_beat(grr_pkg::ActAdd,   6'd0, 6'd9);       // endpoint out of range, dropped
    send_beat(grr_pkg::ActAdd,   6'd4, 6'd5);
    send_beat(grr_pkg::ActAdd,   6'd5, 6'd3);
    send_beat(grr_pkg::ActQuery, 6'd4, 6'd1);       // 4-5-3-2-1, 3-62 not followed
    send_beat(grr_pkg::ActQuery, 6'd0, 6'd7);       // only link of 0 is to 63, above the count
    send_beat(grr_pkg::ActQuery, 6'd7, 6'd7);
    settle();

    // Random phases; the sender pauses for a full drain before each register write
    for (int p = 0; p < NumPhases; p++) begin
      program_count(PhaseCounts[p]);
      calm = (p == NumPhases - 1);
      if (p == HoldPhase) hold_req = 1'b1;
      run_random(PhaseItems);
      settle();
    end

    repeat (32) @(posedge clk_i);
    if (book.mismatches == 0 && cfg_errors == 0) begin
      $display("graph_reachability regression: pass");
    end else begin
      $display("graph_reachability regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hdl/grr_pkg.sv
hdl/grr_if.sv
hdl/grr_adj_mem.sv
hdl/grr_frontier.sv
hdl/graph_reachability.sv
tb/grr_tb_pkg.sv
tb/graph_reachability_tb.sv
